@@ hw/rtl/q2e_pkg.sv @@
// Package for the quaternion to Euler angle converter.
// Holds widths, stage structs, the arctangent table and helper functions.
// No dependencies.
`default_nettype none

package q2e_pkg;

  localparam int CordicSteps = 16;          // CORDIC iterations, 8..24
  localparam int AngleBits   = 16;          // angle accumulator width, 12..24
  localparam int ZW          = AngleBits + 2;
  localparam int SW          = 35;          // width of the ZYX sums in Q.30
  localparam int VW          = 37;          // CORDIC x/y width, covers gain growth
  localparam int NW          = 61;          // square root radicand width
  localparam int RW          = 62;          // square root partial result width
  localparam int SqrtSteps   = 31;          // one result bit per cell
  localparam int OutRnd      = (AngleBits > 16) ? AngleBits - 17 : 0;
  localparam int OutShr      = (AngleBits > 16) ? AngleBits - 16 : 0;
  localparam int OutShl      = (AngleBits < 16) ? 16 - AngleBits : 0;

  localparam logic signed [15:0] PitchPos = 16'sd16384;
  localparam logic signed [15:0] PitchNeg = -16'sd16384;

  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  // One CORDIC channel: vector, accumulated angle and the both-zero mark.
  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
    logic zero;
  } cv_t;

  // Sums carried alongside the square root chain.
  typedef struct packed {
    sum_t sr;
    sum_t cr;
    sum_t sy;
    sum_t cy;
    sum_t sp;
    logic sat;
  } pl_t;

  // Square root working state.
  typedef struct packed {
    logic [NW-1:0] n;
    logic [RW-1:0] res;
  } sq_t;

  // Pitch flags handed down the CORDIC chain: saturated, positive.
  typedef struct packed {
    logic sat;
    logic pos;
  } ptag_t;

  localparam logic [31:0] AtanTab [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // Table entry rounded to the accumulator resolution.
  function automatic ang_t atan_entry(input logic [4:0] i);
    logic [32:0] t;
    t = {1'b0, AtanTab[i]} + (33'd1 << (31 - AngleBits));
    return ang_t'(t >> (32 - AngleBits));
  endfunction

  // Move a left half plane vector into the right half plane.
  function automatic cv_t prerot(input vec_t ys, input vec_t xs);
    cv_t c;
    c.zero = (xs == '0) && (ys == '0);
    c.z    = '0;
    c.x    = xs;
    c.y    = ys;
    if (xs[VW-1]) begin
      if (!ys[VW-1]) begin
        c.x = ys;
        c.y = -xs;
        c.z = ang_t'(1) <<< (AngleBits - 2);
      end else begin
        c.x = -ys;
        c.y = xs;
        c.z = -(ang_t'(1) <<< (AngleBits - 2));
      end
    end
    return c;
  endfunction

  // Accumulator to 16-bit binary angle, wrapping.
  function automatic logic [15:0] to_out16(input ang_t a);
    logic signed [31:0] t;
    t = 32'(a);
    if (AngleBits > 16) begin
      t = t + (32'sd1 <<< OutRnd);
    end
    t = (t >>> OutShr) <<< OutShl;
    return t[15:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/q2e_if.sv @@
// Stream interfaces for the quaternion input and the Euler angle result.
// Depends on nothing; one beat moves when valid and ready are both high.
`default_nettype none

interface q2e_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_saturated;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/q2e_front.sv @@
// Front end: products, ZYX sums, pitch clamp test and the square root radicand.
// Four register stages. Depends on q2e_pkg.
`default_nettype none

module q2e_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_in,
  input  wire logic signed [15:0] w,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [15:0] z,
  output      logic               vld_out,
  output      q2e_pkg::sq_t       sq_out,
  output      q2e_pkg::pl_t       pl_out
);
  import q2e_pkg::*;

  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;
  logic [3:0]         vld_r;
  pl_t                pl2_r, pl3_r, pl4_r;
  pl_t                pl2_nxt;
  logic [RW-1:0]      sp2_r;
  logic [NW-1:0]      n_r;
  logic signed [30:0] sp31;
  localparam sum_t OneQ30 = sum_t'(1) <<< 30;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_in};
    end
  end

  // Stage 1: products.
  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= w * x;
      yz_r <= y * z;
      xx_r <= x * x;
      yy_r <= y * y;
      wy_r <= w * y;
      zx_r <= z * x;
      wz_r <= w * z;
      xy_r <= x * y;
      zz_r <= z * z;
    end
  end

  // Stage 2: the sums and the arcsine clamp test.
  always_comb begin
    pl2_nxt.sr  = (sum_t'(wx_r) + sum_t'(yz_r)) <<< 1;
    pl2_nxt.cr  = OneQ30 - ((sum_t'(xx_r) + sum_t'(yy_r)) <<< 1);
    pl2_nxt.sp  = (sum_t'(wy_r) - sum_t'(zx_r)) <<< 1;
    pl2_nxt.sy  = (sum_t'(wz_r) + sum_t'(xy_r)) <<< 1;
    pl2_nxt.cy  = OneQ30 - ((sum_t'(yy_r) + sum_t'(zz_r)) <<< 1);
    pl2_nxt.sat = (pl2_nxt.sp >= OneQ30) || (pl2_nxt.sp <= -OneQ30);
  end

  // The square is only used when the sum is below one, so 31 bits suffice.
  assign sp31 = pl2_r.sp[30:0];

  // Stages 2 to 4: square of the pitch sum, then 1 - s^2 in Q.60.
  always_ff @(posedge clk) begin
    if (en) begin
      pl2_r <= pl2_nxt;
      pl3_r <= pl2_r;
      sp2_r <= RW'(sp31 * sp31);
      pl4_r <= pl3_r;
      n_r   <= NW'((RW'(1) << 60) - sp2_r);
    end
  end

  assign vld_out    = vld_r[3];
  assign sq_out.n   = n_r;
  assign sq_out.res = '0;
  assign pl_out     = pl4_r;

endmodule

`default_nettype wire

@@ hw/rtl/q2e_sqrt_cell.sv @@
// One cell of the square root chain: settles one result bit per cell.
// Carries the angle sums along. Depends on q2e_pkg.
`default_nettype none

module q2e_sqrt_cell (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic [4:0]   step,
  input  wire logic         vld_in,
  input  wire q2e_pkg::sq_t sq_in,
  input  wire q2e_pkg::pl_t pl_in,
  output      logic         vld_out,
  output      q2e_pkg::sq_t sq_out,
  output      q2e_pkg::pl_t pl_out
);
  import q2e_pkg::*;

  logic          vld_r;
  sq_t           sq_r, sq_nxt;
  pl_t           pl_r;
  logic [RW-1:0] bitv, trial;

  // Restoring square root step for bit weight 4^(30 - step).
  always_comb begin
    bitv  = RW'(1) << (6'd60 - {step, 1'b0});
    trial = sq_in.res + bitv;
    if ({1'b0, sq_in.n} >= trial) begin
      sq_nxt.n   = sq_in.n - trial[NW-1:0];
      sq_nxt.res = (sq_in.res >> 1) + bitv;
    end else begin
      sq_nxt.n   = sq_in.n;
      sq_nxt.res = sq_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
      pl_r <= pl_in;
    end
  end

  assign vld_out = vld_r;
  assign sq_out  = sq_r;
  assign pl_out  = pl_r;

endmodule

`default_nettype wire

@@ hw/rtl/q2e_cordic_cell.sv @@
// One vectoring CORDIC iteration for the roll, pitch and yaw channels.
// Depends on q2e_pkg.
`default_nettype none

module q2e_cordic_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic [4:0]     step,
  input  wire logic           vld_in,
  input  wire q2e_pkg::cv_t   cv_in [3],
  input  wire q2e_pkg::ptag_t tag_in,
  output      logic           vld_out,
  output      q2e_pkg::cv_t   cv_out [3],
  output      q2e_pkg::ptag_t tag_out
);
  import q2e_pkg::*;

  logic  vld_r;
  cv_t   cv_r [3];
  cv_t   cv_nxt [3];
  ptag_t tag_r;
  vec_t  dx [3];
  vec_t  dy [3];
  ang_t  da;

  assign da = atan_entry(step);

  // Rotate each vector toward the x axis.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dx[c] = cv_in[c].x >>> step;
      dy[c] = cv_in[c].y >>> step;
      cv_nxt[c].zero = cv_in[c].zero;
      if (!cv_in[c].y[VW-1]) begin
        cv_nxt[c].x = cv_in[c].x + dy[c];
        cv_nxt[c].y = cv_in[c].y - dx[c];
        cv_nxt[c].z = cv_in[c].z + da;
      end else begin
        cv_nxt[c].x = cv_in[c].x - dy[c];
        cv_nxt[c].y = cv_in[c].y + dx[c];
        cv_nxt[c].z = cv_in[c].z - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cv_r  <= cv_nxt;
      tag_r <= tag_in;
    end
  end

  assign vld_out = vld_r;
  assign cv_out  = cv_r;
  assign tag_out = tag_r;

endmodule

`default_nettype wire

@@ hw/rtl/quaternion_to_euler.sv @@
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_if, q2e_front, q2e_sqrt_cell and q2e_cordic_cell.
//
// Usage:
//   in_ch carries one unit quaternion (w, x, y, z) in signed Q1.15 per beat.
//   out_ch carries roll, pitch and yaw as 16-bit binary angles (32768 counts
//   equal pi) and a flag that is set when pitch was clamped to a quarter turn.
//   Every input beat yields exactly one output beat, in order.
//   From an accepted input beat to out_ch.valid a beat passes through four
//   front-end stages, 31 square root cells, one pre-rotation stage, 16 CORDIC
//   cells and the output register. The pipeline takes one beat per cycle while it is not held.
//   The whole pipeline advances together; it holds when the output register
//   is full and the receiver keeps ready low, and in_ch.ready follows.
//   Reset (synchronous, rst_n low) empties the pipeline; beats in flight are
//   dropped and no beat is produced by it.
`default_nettype none

module quaternion_to_euler (
  input wire logic   clk,
  input wire logic   rst_n,
  q2e_quat_if.sink   in_ch,
  q2e_euler_if.source out_ch
);
  import q2e_pkg::*;

  logic               en;
  logic               sq_vld [SqrtSteps+1];
  sq_t                sq_d   [SqrtSteps+1];
  pl_t                pl_d   [SqrtSteps+1];
  logic               cd_vld [CordicSteps+1];
  cv_t                cd_d   [CordicSteps+1][3];
  ptag_t              cd_tag [CordicSteps+1];
  logic               pre_vld_r;
  cv_t                pre_r [3];
  ptag_t              pre_tag_r;
  pl_t                pl_last;
  logic               out_valid_r;
  logic signed [15:0] roll_r, pitch_r, yaw_r;
  logic               sat_r;
  logic [15:0]        roll_nxt, pitch_nxt, yaw_nxt;

  // Pipeline moves whenever the output register can take a beat.
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  q2e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_ch.valid),
    .w       (in_ch.quat_w),
    .x       (in_ch.quat_x),
    .y       (in_ch.quat_y),
    .z       (in_ch.quat_z),
    .vld_out (sq_vld[0]),
    .sq_out  (sq_d[0]),
    .pl_out  (pl_d[0])
  );

  // Square root chain for cos(pitch) = sqrt(1 - s^2).
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .step    (5'(k)),
      .vld_in  (sq_vld[k]),
      .sq_in   (sq_d[k]),
      .pl_in   (pl_d[k]),
      .vld_out (sq_vld[k+1]),
      .sq_out  (sq_d[k+1]),
      .pl_out  (pl_d[k+1])
    );
  end

  assign pl_last = pl_d[SqrtSteps];

  // Pre-rotation into the right half plane for all three channels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= 1'b0;
    end else if (en) begin
      pre_vld_r <= sq_vld[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r[0]      <= prerot(vec_t'(pl_last.sr), vec_t'(pl_last.cr));
      pre_r[1]      <= prerot(vec_t'(pl_last.sp), vec_t'(sq_d[SqrtSteps].res[30:0]));
      pre_r[2]      <= prerot(vec_t'(pl_last.sy), vec_t'(pl_last.cy));
      pre_tag_r.sat <= pl_last.sat;
      pre_tag_r.pos <= !pl_last.sp[SW-1] && (pl_last.sp != '0);
    end
  end

  assign cd_vld[0] = pre_vld_r;
  assign cd_d[0]   = pre_r;
  assign cd_tag[0] = pre_tag_r;

  // CORDIC chain, one iteration per cell.
  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    q2e_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .step    (5'(k)),
      .vld_in  (cd_vld[k]),
      .cv_in   (cd_d[k]),
      .tag_in  (cd_tag[k]),
      .vld_out (cd_vld[k+1]),
      .cv_out  (cd_d[k+1]),
      .tag_out (cd_tag[k+1])
    );
  end

  // Scale the angles to 16 bits and apply the pitch clamp.
  always_comb begin
    roll_nxt  = cd_d[CordicSteps][0].zero ? '0 : to_out16(cd_d[CordicSteps][0].z);
    yaw_nxt   = cd_d[CordicSteps][2].zero ? '0 : to_out16(cd_d[CordicSteps][2].z);
    pitch_nxt = cd_d[CordicSteps][1].zero ? '0 : to_out16(cd_d[CordicSteps][1].z);
    if (cd_tag[CordicSteps].sat) begin
      pitch_nxt = cd_tag[CordicSteps].pos ? PitchPos : PitchNeg;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cd_vld[CordicSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
      sat_r   <= cd_tag[CordicSteps].sat;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.roll_angle      = roll_r;
  assign out_ch.pitch_angle     = pitch_r;
  assign out_ch.yaw_angle       = yaw_r;
  assign out_ch.pitch_saturated = sat_r;

endmodule

`default_nettype wire

@@ hw/rtl/q2e_checker.sv @@
// Port-level checks for quaternion_to_euler, attached by bind.
// Depends on q2e_pkg and the top level's ports.
`default_nettype none

module q2e_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] pitch_angle,
  input wire logic               pitch_saturated
);
  import q2e_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Reset leaves no result beat behind.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // A clamped pitch is exactly a quarter turn.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pitch_saturated |-> pitch_angle == PitchPos || pitch_angle == PitchNeg)
    else $error("clamped pitch is not a quarter turn");

  // Pitch never goes past a quarter turn.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pitch_angle <= PitchPos && pitch_angle >= PitchNeg)
    else $error("pitch beyond a quarter turn");

endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .pitch_angle     (out_ch.pitch_angle),
  .pitch_saturated (out_ch.pitch_saturated)
);

`default_nettype wire

@@ sim/quaternion_to_euler_tb.sv @@
// Testbench for the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_if and the quaternion_to_euler RTL; it computes the
// expected angles bit for bit with its own CORDIC model and checks every beat.
`timescale 1ns / 1ps

module quaternion_to_euler_tb;
  import q2e_pkg::*;

  localparam int StepCount = (CordicSteps < 1) ? 1 : ((CordicSteps > 24) ? 24 : CordicSteps);
  localparam int AccBits   = (AngleBits < 12) ? 12 : ((AngleBits > 24) ? 24 : AngleBits);
  localparam longint OneQ30 = 64'sd1 << 30;
  localparam int PipeDepth = 53;
  localparam longint CycleLimit = 64'd1_500_000;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic        sat;
  } euler_t;

  // One directed row; has_angles marks rows whose result is typed in.
  typedef struct {
    logic [15:0] w, x, y, z;
    bit          has_angles;
    euler_t      angles;
  } quat_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  longint cycle_count = 0;
  int error_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  euler_t expected_angles[$];

  q2e_quat_if  quat_ch();
  q2e_euler_if euler_ch();

  quaternion_to_euler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (quat_ch),
    .out_ch (euler_ch)
  );

  always #5 clk = ~clk;

  // Hard limit on run time.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Arctangent table entry at accumulator resolution.
  function automatic longint atan_step(input int i);
    longint t;
    t = longint'(AtanTab[i]);
    return (t + (64'sd1 << (31 - AccBits))) >>> (32 - AccBits);
  endfunction

  // Vectoring CORDIC arctangent of ys/xs in accumulator counts.
  function automatic longint vector_angle(input longint ys, input longint xs);
    longint acc, t, dx, dy;
    acc = 0;
    if (xs == 0 && ys == 0) return 0;
    if (xs < 0) begin
      t = xs;
      if (ys >= 0) begin
        xs = ys; ys = -t; acc = 64'sd1 << (AccBits - 2);
      end else begin
        xs = -ys; ys = t; acc = -(64'sd1 << (AccBits - 2));
      end
    end
    for (int i = 0; i < StepCount; i++) begin
      dx = xs >>> i;
      dy = ys >>> i;
      if (ys >= 0) begin
        xs += dy; ys -= dx; acc += atan_step(i);
      end else begin
        xs -= dy; ys += dx; acc -= atan_step(i);
      end
    end
    return acc;
  endfunction

  // Floor square root of a 64-bit radicand.
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Accumulator to the 16-bit output angle, wrapping.
  function automatic logic [15:0] angle_code(input longint a);
    longint unsigned u;
    u = a;
    if (AccBits > 16) return 16'((u + (64'd1 << (AccBits - 17))) >> (AccBits - 16));
    return 16'(u << (16 - AccBits));
  endfunction

  // Expected Euler angles for one quaternion.
  function automatic euler_t euler_angles(input logic signed [15:0] qw, qx, qy, qz);
    longint w, x, y, z, sr, cr, sp, sy, cy, cp;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    sr = 2 * (w * x + y * z);
    cr = OneQ30 - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = OneQ30 - 2 * (y * y + z * z);
    if (sp >= OneQ30 || sp <= -OneQ30) begin
      e.sat = 1'b1;
      e.pitch = (sp > 0) ? PitchPos : PitchNeg;
    end else begin
      cp = floor_sqrt((64'd1 << 60) - longint'(sp * sp));
      e.sat = 1'b0;
      e.pitch = angle_code(vector_angle(sp, cp));
    end
    e.roll = angle_code(vector_angle(sr, cr));
    e.yaw = angle_code(vector_angle(sy, cy));
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got, exp_v);
    $display("mismatch %s: got %0d expected %0d at cycle %0d",
             what, $signed(got), $signed(exp_v), cycle_count);
    error_count++;
  endtask

  // Receiver: random stall, check each result beat against the oldest expectation.
  initial begin
    euler_t e;
    euler_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && euler_ch.valid && euler_ch.ready) begin
        if (expected_angles.size() == 0) begin
          $display("unexpected result beat at cycle %0d", cycle_count);
          error_count++;
        end else begin
          e = expected_angles.pop_front();
          if (euler_ch.roll_angle != e.roll) report_mismatch("roll", euler_ch.roll_angle, e.roll);
          if (euler_ch.pitch_angle != e.pitch)
            report_mismatch("pitch", euler_ch.pitch_angle, e.pitch);
          if (euler_ch.yaw_angle != e.yaw) report_mismatch("yaw", euler_ch.yaw_angle, e.yaw);
          if (euler_ch.pitch_saturated != e.sat)
            report_mismatch("sat", euler_ch.pitch_saturated, e.sat);
        end
      end
      euler_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Random component: raw bits, a value within +-16383, or a small offset within +-1000.
  function automatic logic [15:0] rand_part(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32766)) - 16383);
      default: return 16'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // Send one quaternion beat, waiting for acceptance. Valid stays high into
  // the next beat unless the sender idles first.
  task automatic send_quat(input logic [15:0] w, x, y, z);
    while ($urandom_range(99) < idle_pct) begin
      quat_ch.valid <= 1'b0;
      @(posedge clk);
    end
    quat_ch.valid <= 1'b1;
    quat_ch.quat_w <= w;
    quat_ch.quat_x <= x;
    quat_ch.quat_y <= y;
    quat_ch.quat_z <= z;
    do @(posedge clk); while (!quat_ch.ready);
    expected_angles.push_back(euler_angles(w, x, y, z));
  endtask

  // Stimulus.
  initial begin
    quat_row_t rows[$];
    quat_row_t r;
    euler_t e;
    int mode, n;
    quat_ch.valid <= 1'b0;
    quat_ch.quat_w <= '0;
    quat_ch.quat_x <= '0;
    quat_ch.quat_y <= '0;
    quat_ch.quat_z <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: identity, all zero, pitch clamp both ways, extremes.
    rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, '{16'h0, 16'h0, 16'h0, 1'b0}});
    rows.push_back('{16'h7fff, 16'h0000, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h7fff, 16'h0000, 16'h4001, 16'h0000, 1,
                     '{16'h0, PitchPos, 16'h0, 1'b1}});
    rows.push_back('{16'h7fff, 16'h0000, 16'hbfff, 16'h0000, 1,
                     '{16'h0, PitchNeg, 16'h0, 1'b1}});
    rows.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0});
    rows.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, '0});
    rows.push_back('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0, '0});
    rows.push_back('{16'h0000, 16'h7fff, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 0, '0});
    rows.push_back('{16'h0000, 16'h8000, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h5a82, 16'h5a82, 16'h0000, 16'h0000, 0, '0});
    rows.push_back('{16'h5a82, 16'h0000, 16'h0000, 16'ha57e, 0, '0});
    rows.push_back('{16'h0001, 16'hffff, 16'h0001, 16'hffff, 0, '0});
    rows.push_back('{16'h7fff, 16'h0000, 16'h0000, 16'h0001, 0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      send_quat(r.w, r.x, r.y, r.z);
      if (r.has_angles) begin
        e = euler_angles(r.w, r.x, r.y, r.z);
        if (e != r.angles) begin
          $display("directed row %0d disagrees with typed result", i);
          error_count++;
        end
      end
    end
    quat_ch.valid <= 1'b0;

    // Hold off until every expected result has drained.
    while (expected_angles.size() != 0) @(posedge clk);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 86 : ((ph == 3) ? 22 : 0);
      stall_pct = (ph == 2) ? 86 : ((ph == 3) ? 22 : 0);
      n = (ph == 0) ? 700 : 400;
      for (int k = 0; k < n; k++) begin
        mode = $urandom_range(9);
        if (mode < 2) send_quat(rand_part(0), rand_part(0), rand_part(0), rand_part(0));
        else if (mode < 9) send_quat(rand_part(1), rand_part(1), rand_part(1), rand_part(1));
        else send_quat(16'h5a82 + rand_part(2), rand_part(2),
                       16'h5a82 + rand_part(2), rand_part(2));
      end
    end
    quat_ch.valid <= 1'b0;

    idle_pct = 0;
    stall_pct = 0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (PipeDepth + 20) @(posedge clk);
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
